[rtl/lg3fs_pkg.sv]
// Shared constants, types and helpers for the cubic Lagrange fractional shifter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lg3fs_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int FRACTION_BITS = 16;
  localparam int MAX_DELAY     = 63;

  // Shift register layout: signed integer part above FRACTION_BITS fraction bits.
  localparam int SHIFT_BITS = 33;
  localparam int INT_BITS   = SHIFT_BITS - FRACTION_BITS;
  localparam int DELAY_BITS = $clog2(MAX_DELAY + 1);
  localparam int DROP_BITS  = INT_BITS;

  // Smallest fraction code that is at least one millionth of a sample.
  localparam longint FRAC_MIN =
    ((longint'(1) << FRACTION_BITS) + 64'd999999) / 64'd1000000;

  // Interpolator datapath widths. The Horner accumulator stays below
  // 2^(SAMPLE_BITS+5) in magnitude.
  localparam int ACC_W  = SAMPLE_BITS + 8;
  localparam int MB_W   = (SAMPLE_BITS + 4 > FRACTION_BITS + 1) ?
                          SAMPLE_BITS + 4 : FRACTION_BITS + 1;
  localparam int PROD_W = ACC_W + MB_W;

  // floor(m / 3) = (m * DIV3_RECIP) >> DIV_K, exact for 0 <= m < 2^(DIV_K-1).
  localparam int     DIV_K      = SAMPLE_BITS + 4;
  localparam longint DIV3_RECIP = (longint'(1) << DIV_K) / 3 + 1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SHIFT_BITS-1:0]  shift_t;
  typedef logic        [FRACTION_BITS-1:0] frac_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic signed [MB_W-1:0]        mulb_t;
  typedef logic signed [PROD_W-1:0]      prod_t;

  // Four neighbors, newest first, and the fraction.
  typedef struct packed {
    sample_t ym1;
    sample_t y0;
    sample_t y1;
    sample_t y2;
    frac_t   frac;
  } lg3fs_taps_t;

  typedef struct packed {
    logic        start;
    lg3fs_taps_t taps;
  } lg3fs_req_t;

  typedef struct packed {
    logic    valid;
    sample_t value;
  } lg3fs_rsp_t;

  function automatic acc_t sx_acc(sample_t v);
    return {{(ACC_W - SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
  endfunction

endpackage

`default_nettype wire

[rtl/lg3fs_if.sv]
// Valid/ready channel interfaces: sample input, sample result, shift configuration.
// Depends on lg3fs_pkg for the payload types.
`default_nettype none

interface lg3fs_in_if;
  import lg3fs_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;
  logic    last_in;
  modport source (output valid, output sample_in, output last_in, input ready);
  modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

interface lg3fs_out_if;
  import lg3fs_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    last_out;
  modport source (output valid, output sample_out, output last_out, input ready);
  modport sink   (input valid, input sample_out, input last_out, output ready);
endinterface

interface lg3fs_cfg_if;
  import lg3fs_pkg::*;
  logic   valid;
  logic   ready;
  shift_t shift_q16;
  modport source (output valid, output shift_q16, input ready);
  modport sink   (input valid, input shift_q16, output ready);
endinterface

`default_nettype wire

[rtl/lg3fs_interp.sv]
// Cubic Lagrange interpolator: one shared multiplier and adder under a step counter.
// Horner evaluation, rounding, divide by six and saturation. Depends on lg3fs_pkg.
`default_nettype none

module lg3fs_interp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lg3fs_pkg::lg3fs_req_t req,
  output lg3fs_pkg::lg3fs_rsp_t rsp
);
  import lg3fs_pkg::*;

  localparam logic [2:0] ST_MUL_K3  = 3'd0;
  localparam logic [2:0] ST_ADD_K2  = 3'd1;
  localparam logic [2:0] ST_MUL_A1  = 3'd2;
  localparam logic [2:0] ST_ADD_K1  = 3'd3;
  localparam logic [2:0] ST_MUL_A2  = 3'd4;
  localparam logic [2:0] ST_ADD_C0  = 3'd5;
  localparam logic [2:0] ST_MUL_DIV = 3'd6;
  localparam logic [2:0] ST_FINISH  = 3'd7;

  localparam acc_t DIV_LIM = acc_t'(3) <<< (SAMPLE_BITS - 1);

  logic       busy_r, busy_nxt;
  logic [2:0] step_r, step_nxt;
  logic       res_valid_r, res_valid_nxt;

  acc_t    k3_r, k2_r, k1_r, c0_r;
  frac_t   f_r;
  acc_t    acc_r, acc_nxt;
  prod_t   prod_r, prod_nxt;
  sample_t res_r, res_nxt;

  acc_t  ym1, y0, y1, y2, d01, s2;
  acc_t  k3, k2, k1, c0;
  acc_t  mul_a, addend, rnd, n_plus, m_half, m_clamp;
  mulb_t mul_b;
  prod_t rnd_wide;

  // Coefficients from the taps, scaled by six.
  always_comb begin
    ym1 = sx_acc(req.taps.ym1);
    y0  = sx_acc(req.taps.y0);
    y1  = sx_acc(req.taps.y1);
    y2  = sx_acc(req.taps.y2);
    d01 = y0 - y1;
    s2  = ym1 + y1 - (y0 <<< 1);
    k3  = y2 - ym1 + (d01 <<< 1) + d01;
    k2  = (s2 <<< 1) + s2;
    k1  = (y1 <<< 2) + (y1 <<< 1) - (ym1 <<< 1) - (y0 <<< 1) - y0 - y2;
    c0  = (y0 <<< 2) + (y0 <<< 1);
  end

  // Divide-by-six prep: floor((a+3)/2), clamp to the range that maps onto
  // the output range, then bias to nonnegative for the reciprocal multiply.
  always_comb begin
    n_plus = acc_r + acc_t'(3);
    m_half = n_plus >>> 1;
    if (m_half < -DIV_LIM) begin
      m_clamp = -DIV_LIM;
    end else if (m_half > DIV_LIM - acc_t'(1)) begin
      m_clamp = DIV_LIM - acc_t'(1);
    end else begin
      m_clamp = m_half;
    end
  end

  // Shared multiplier operand select.
  always_comb begin
    if (step_r == ST_MUL_K3) begin
      mul_a = k3_r;
    end else if (step_r == ST_MUL_DIV) begin
      mul_a = m_clamp + DIV_LIM;
    end else begin
      mul_a = acc_r;
    end
    if (step_r == ST_MUL_DIV) begin
      mul_b = mulb_t'(DIV3_RECIP);
    end else begin
      mul_b = mulb_t'({1'b0, f_r});
    end
  end

  assign prod_nxt = prod_t'(mul_a) * prod_t'(mul_b);

  // Shared adder: round the product back to sample scale and add a coefficient.
  always_comb begin
    rnd_wide = (prod_r + (prod_t'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    rnd      = rnd_wide[ACC_W-1:0];
    if (step_r == ST_ADD_K2) begin
      addend = k2_r;
    end else if (step_r == ST_ADD_K1) begin
      addend = k1_r;
    end else begin
      addend = c0_r;
    end
    acc_nxt = rnd + addend;
  end

  // Quotient is biased by half the range: undo it by flipping the top bit.
  assign res_nxt = {~prod_r[DIV_K + SAMPLE_BITS - 1], prod_r[DIV_K +: SAMPLE_BITS - 1]};

  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    res_valid_nxt = res_valid_r;
    if (req.start) begin
      busy_nxt      = 1'b1;
      step_nxt      = ST_MUL_K3;
      res_valid_nxt = 1'b0;
    end else if (busy_r) begin
      step_nxt = step_r + 3'd1;
      if (step_r == ST_FINISH) begin
        busy_nxt      = 1'b0;
        res_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= ST_MUL_K3;
      res_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      k3_r <= k3;
      k2_r <= k2;
      k1_r <= k1;
      c0_r <= c0;
      f_r  <= req.taps.frac;
    end
    if (busy_r) begin
      unique case (step_r)
        ST_MUL_K3, ST_MUL_A1, ST_MUL_A2, ST_MUL_DIV: prod_r <= prod_nxt;
        ST_ADD_K2, ST_ADD_K1, ST_ADD_C0:             acc_r  <= acc_nxt;
        ST_FINISH:                                   res_r  <= res_nxt;
      endcase
    end
  end

  assign rsp.valid = res_valid_r;
  assign rsp.value = res_r;

endmodule

`default_nettype wire

[rtl/lagrange3_fractional_shifter_core.sv]
// Top level of the cubic Lagrange fractional shifter: stream sequencer,
// history, output register. Depends on lg3fs_pkg, lg3fs_if and lg3fs_interp.
`default_nettype none

//  channel  | direction | payload                     | transfer when
//  ---------+-----------+-----------------------------+---------------------------
//  in_ch    | sink      | sample_in (s24), last_in    | in_ch.valid & in_ch.ready
//  out_ch   | source    | sample_out (s24), last_out  | out_ch.valid & out_ch.ready
//  cfg_ch   | sink      | shift_q16 (s33, Q16)        | cfg_ch.valid & cfg_ch.ready
//
//  One input transfer at a time; in_ch.ready is high only while the sequencer
//  idles. A dropped sample goes straight back to idle. A pushed sample with a
//  fraction waits on the shared multiplier of the interpolator once the history
//  holds a sample, and the stream's last sample waits on it once more.
//  The first sample of a stream also runs one push per delay zero (up to 63).
//  A full output register stalls the sequencer before it emits; rst_n
//  (synchronous) clears the stream state and the shift register.

module lagrange3_fractional_shifter_core (
  input logic         clk,
  input logic         rst_n,
  lg3fs_in_if.sink    in_ch,
  lg3fs_out_if.source out_ch,
  lg3fs_cfg_if.sink   cfg_ch
);
  import lg3fs_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DISP  = 3'd1;
  localparam logic [2:0] ST_PUSH  = 3'd2;
  localparam logic [2:0] ST_CALC1 = 3'd3;
  localparam logic [2:0] ST_SHIFT = 3'd4;
  localparam logic [2:0] ST_CALC2 = 3'd5;
  localparam logic [2:0] ST_POST  = 3'd6;

  logic [2:0] state_r, state_nxt;

  shift_t shift_r;

  // Stream state, latched on the first sample of a stream.
  logic                  active_r, active_nxt;
  logic [DELAY_BITS-1:0] delay_cnt_r, delay_cnt_nxt;
  logic [DROP_BITS-1:0]  drop_r, drop_nxt;
  logic [DROP_BITS-1:0]  dropped_r, dropped_nxt;
  frac_t                 frac_r, frac_nxt;
  sample_t               hist0_r, hist0_nxt, hist1_r, hist1_nxt, hist2_r, hist2_nxt;
  logic                  hist_valid_r, hist_valid_nxt;

  // Current input item and the sample being pushed.
  sample_t x_r, x_nxt;
  logic    x_last_r, x_last_nxt;
  sample_t cur_v_r, cur_v_nxt;
  logic    cur_last_r, cur_last_nxt;
  logic    item_pushed_r, item_pushed_nxt;

  // Output register.
  logic    out_valid_r, out_valid_nxt;
  sample_t out_sample_r, out_sample_nxt;
  logic    out_last_r, out_last_nxt;

  logic       in_fire, out_free, emit;
  lg3fs_req_t req;
  lg3fs_rsp_t rsp;

  logic signed [INT_BITS-1:0] int_part;
  logic [DELAY_BITS-1:0]      start_delay;
  logic [DROP_BITS-1:0]       start_drop;
  frac_t                      start_frac;

  lg3fs_interp u_interp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Split the shift: floor part, fraction. Clamp the delay, negate the advance,
  // and treat a fraction below one millionth of a sample as none.
  assign int_part = shift_r[SHIFT_BITS-1:FRACTION_BITS];

  always_comb begin
    start_delay = '0;
    start_drop  = '0;
    if (int_part[INT_BITS-1]) begin
      start_drop = DROP_BITS'(~int_part) + DROP_BITS'(1);
    end else if (int_part != '0) begin
      if ($unsigned(int_part) > INT_BITS'(MAX_DELAY)) begin
        start_delay = DELAY_BITS'(MAX_DELAY);
      end else begin
        start_delay = int_part[DELAY_BITS-1:0];
      end
    end
    if (shift_r[FRACTION_BITS-1:0] >= FRACTION_BITS'(FRAC_MIN)) begin
      start_frac = shift_r[FRACTION_BITS-1:0];
    end else begin
      start_frac = '0;
    end
  end

  // Sequencer: per input item, push the delay zeros (first item only), then
  // either drop the item or push it. A push emits directly without a fraction;
  // with one it interpolates over the history once the history holds a sample,
  // shifts the history, and flushes one more interpolation on the last sample.
  always_comb begin
    state_nxt       = state_r;
    active_nxt      = active_r;
    delay_cnt_nxt   = delay_cnt_r;
    drop_nxt        = drop_r;
    dropped_nxt     = dropped_r;
    frac_nxt        = frac_r;
    hist0_nxt       = hist0_r;
    hist1_nxt       = hist1_r;
    hist2_nxt       = hist2_r;
    hist_valid_nxt  = hist_valid_r;
    x_nxt           = x_r;
    x_last_nxt      = x_last_r;
    cur_v_nxt       = cur_v_r;
    cur_last_nxt    = cur_last_r;
    item_pushed_nxt = item_pushed_r;
    out_sample_nxt  = out_sample_r;
    out_last_nxt    = out_last_r;
    emit            = 1'b0;
    req.start       = 1'b0;
    req.taps.ym1    = cur_v_r;
    req.taps.y0     = hist0_r;
    req.taps.y1     = hist1_r;
    req.taps.y2     = hist2_r;
    req.taps.frac   = frac_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          x_nxt           = in_ch.sample_in;
          x_last_nxt      = in_ch.last_in;
          item_pushed_nxt = 1'b0;
          if (!active_r) begin
            active_nxt    = 1'b1;
            delay_cnt_nxt = start_delay;
            drop_nxt      = start_drop;
            frac_nxt      = start_frac;
          end
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        if (delay_cnt_r != '0) begin
          cur_v_nxt     = '0;
          cur_last_nxt  = 1'b0;
          delay_cnt_nxt = delay_cnt_r - DELAY_BITS'(1);
          state_nxt     = ST_PUSH;
        end else if (!x_last_r && (dropped_r < drop_r)) begin
          dropped_nxt = dropped_r + DROP_BITS'(1);
          state_nxt   = ST_IDLE;
        end else begin
          cur_v_nxt       = x_r;
          cur_last_nxt    = x_last_r;
          item_pushed_nxt = 1'b1;
          state_nxt       = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (frac_r == '0) begin
          if (out_free) begin
            emit           = 1'b1;
            out_sample_nxt = cur_v_r;
            out_last_nxt   = cur_last_r;
            state_nxt      = ST_POST;
          end
        end else if (hist_valid_r) begin
          req.start = 1'b1;
          state_nxt = ST_CALC1;
        end else begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_CALC1: begin
        if (rsp.valid && out_free) begin
          emit           = 1'b1;
          out_sample_nxt = rsp.value;
          out_last_nxt   = 1'b0;
          state_nxt      = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        hist0_nxt      = cur_v_r;
        hist1_nxt      = hist0_r;
        hist2_nxt      = hist1_r;
        hist_valid_nxt = 1'b1;
        if (cur_last_r) begin
          // Flush: the sample after the last one counts as zero.
          req.start    = 1'b1;
          req.taps.ym1 = '0;
          req.taps.y0  = cur_v_r;
          req.taps.y1  = hist0_r;
          req.taps.y2  = hist1_r;
          state_nxt    = ST_CALC2;
        end else begin
          state_nxt = ST_POST;
        end
      end
      ST_CALC2: begin
        if (rsp.valid && out_free) begin
          emit           = 1'b1;
          out_sample_nxt = rsp.value;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_POST;
        end
      end
      ST_POST: begin
        if (item_pushed_r) begin
          if (cur_last_r) begin
            // End of stream: back to the reset state for the next one.
            active_nxt     = 1'b0;
            dropped_nxt    = '0;
            hist0_nxt      = '0;
            hist1_nxt      = '0;
            hist2_nxt      = '0;
            hist_valid_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_DISP;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold a result until the sink takes it; load a new one on emit.
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      shift_r       <= '0;
      active_r      <= 1'b0;
      delay_cnt_r   <= '0;
      drop_r        <= '0;
      dropped_r     <= '0;
      frac_r        <= '0;
      hist0_r       <= '0;
      hist1_r       <= '0;
      hist2_r       <= '0;
      hist_valid_r  <= 1'b0;
      item_pushed_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      if (cfg_ch.valid) begin
        shift_r <= cfg_ch.shift_q16;
      end
      active_r      <= active_nxt;
      delay_cnt_r   <= delay_cnt_nxt;
      drop_r        <= drop_nxt;
      dropped_r     <= dropped_nxt;
      frac_r        <= frac_nxt;
      hist0_r       <= hist0_nxt;
      hist1_r       <= hist1_nxt;
      hist2_r       <= hist2_nxt;
      hist_valid_r  <= hist_valid_nxt;
      item_pushed_r <= item_pushed_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    x_last_r     <= x_last_nxt;
    cur_v_r      <= cur_v_nxt;
    cur_last_r   <= cur_last_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_sample_r;
  assign out_ch.last_out   = out_last_r;

endmodule

`default_nettype wire
